[src/assert_macros.svh]
// Assertion macros shared by the gradient magnitude block.
// Users need signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

[src/mgm_pkg.sv]
// Types and constants of the multichannel gradient magnitude block.
// No dependencies.
`timescale 1ns / 1ps
package mgm_pkg;
  localparam int POS_W      = 14;  // frame position and effective sizes
  localparam int CFG_W      = 13;
  localparam int FEAT_W     = 16;
  localparam int DIFF_W     = 17;
  localparam int GRAD_W     = 35;
  localparam int ABS_W      = 34;
  localparam int HALF_W     = 17;
  localparam int PROD_W     = 35;
  localparam int SUM_W      = 70;
  localparam int Q_W        = 40;
  localparam int ROOT_W     = 20;
  localparam int REM_W      = 23;
  localparam int ITER_W     = 5;
  localparam int ROOT_STEPS = 20;
  localparam int MAG_W      = 19;
  localparam int NBR_COUNT  = 8;
  localparam int AXIAL_SHIFT = 15;

  localparam logic signed [15:0]   DIAG_WEIGHT = 16'sd23170;
  localparam logic [MAG_W-1:0]     MAG_LIMIT   = 19'd524287;
  localparam logic [CFG_W-1:0]     WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0]     HEIGHT_RESET = 13'd480;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // neighbor slots in a job, row-major without the centre
  localparam int NB_TL = 0;
  localparam int NB_T  = 1;
  localparam int NB_TR = 2;
  localparam int NB_L  = 3;
  localparam int NB_R  = 4;
  localparam int NB_BL = 5;
  localparam int NB_B  = 6;
  localparam int NB_BR = 7;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } nbr_mask_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GRAD,
    B_SQR,
    B_SUM,
    B_MAX,
    B_ROOT,
    B_DONE
  } back_state_t;
endpackage

[src/mgm_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[src/mgm_fifo.sv]
// Two-entry job queue between the front and back parts.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mgm_fifo #(
  parameter int WIDTH = 273
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       count_r, count_nxt;

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  `ASSERT_NEVER(a_no_overflow, push && full)
  `ASSERT_NEVER(a_no_underflow, pop && empty)
  `ASSERT_ALWAYS(a_ptr_count, (count_r == 2'd1) == (wptr_r != rptr_r))
endmodule

[src/mgm_front.sv]
// Front part: accepts pixels, tracks the frame position, keeps the line stores
// and the 3x3 window, and queues masked neighbor differences. Uses mgm_pkg, mgm_ram.
`timescale 1ns / 1ps
module mgm_front #(
  parameter int MAX_WIDTH     = 4096,
  parameter int FEATURE_COUNT = 2,
  parameter int JOB_W         = 273
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mgm_pkg::FEAT_W-1:0]  in_feature_first,
  input  logic [mgm_pkg::FEAT_W-1:0]  in_feature_second,
  input  logic                        in_is_padding,
  input  logic                        cfg_valid,
  input  logic                        cfg_index,
  input  logic [mgm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [JOB_W-1:0]            q_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = mgm_pkg::FEAT_W * FEATURE_COUNT;
  localparam int PW = mgm_pkg::POS_W;
  localparam int DW = mgm_pkg::DIFF_W;

  logic [mgm_pkg::CFG_W-1:0] width_r, height_r;
  logic [CW-1:0]             col_r, col_nxt;
  logic [PW-1:0]             row_r, row_nxt;

  logic [PW-1:0]      w_eff, h_eff, h_p1, cx;
  logic               bad, emit_a, emit_b, is_last, accept;
  logic [CW-1:0]      c;
  logic [PW-1:0]      r;
  mgm_pkg::nbr_mask_t mask;
  logic [FW-1:0]      cur;

  logic                  s1_v_r, s1_emit_r, s1_last_r, s1_go;
  logic [CW-1:0]         s1_col_r;
  logic [FW-1:0]         s1_cur_r;
  mgm_pkg::nbr_mask_t    s1_mask_r;
  logic                  byp_v_r;
  logic [FW-1:0]         byp_a_r, byp_b_r;
  logic [FW-1:0]         rd_a, rd_b, rd_a_eff, rd_b_eff;
  logic [FW-1:0]         lcol_r [3];
  logic [FW-1:0]         ccol_r [3];
  logic [FW-1:0]         ncol [3];

  // effective frame size and position of this item
  always_comb begin
    if (width_r == '0) begin
      w_eff = PW'(1);
    end else if (PW'(width_r) > PW'(MAX_WIDTH)) begin
      w_eff = PW'(MAX_WIDTH);
    end else begin
      w_eff = PW'(width_r);
    end
    h_eff = (height_r == '0) ? PW'(1) : PW'(height_r);
    h_p1  = h_eff + PW'(1);
    bad   = (PW'(col_r) >= w_eff) || (row_r > h_p1) || ((row_r == h_p1) && (col_r != '0));
    c     = bad ? '0 : col_r;
    r     = bad ? '0 : row_r;
    cx    = PW'(c);

    emit_a  = (c != '0) && (r >= PW'(1)) && (r <= h_eff);
    emit_b  = (c == '0) && (r >= PW'(2));
    is_last = (r == h_p1);
    if (emit_a) begin
      mask.top    = (r == PW'(1));
      mask.bottom = (r == h_eff);
      mask.left   = (c == CW'(1));
      mask.right  = 1'b0;
    end else begin
      mask.top    = (r == PW'(2));
      mask.bottom = (r == h_p1);
      mask.left   = (w_eff == PW'(1));
      mask.right  = 1'b1;
    end

    if (is_last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cx + PW'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = r + PW'(1);
    end else begin
      col_nxt = c + CW'(1);
      row_nxt = r;
    end

    // padding reads as zero, and features past the second read as zero
    cur = in_is_padding ? '0 : FW'({in_feature_second, in_feature_first});
  end

  assign s1_go    = s1_v_r && (!s1_emit_r || !q_full);
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_v_r && s1_emit_r && !q_full;

  // config and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mgm_pkg::WIDTH_RESET;
      height_r <= mgm_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mgm_pkg::REG_WIDTH:  width_r  <= cfg_data;
        mgm_pkg::REG_HEIGHT: height_r <= cfg_data;
        default:             width_r  <= width_r;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      byp_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r  <= 1'b1;
        byp_v_r <= s1_go && (c == s1_col_r);
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= c;
      s1_cur_r  <= cur;
      s1_emit_r <= emit_a || emit_b;
      s1_mask_r <= mask;
      s1_last_r <= is_last;
      // forward the write that lands on the address just read
      byp_a_r   <= s1_cur_r;
      byp_b_r   <= rd_a_eff;
    end
    if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        lcol_r[i] <= ccol_r[i];
        ccol_r[i] <= ncol[i];
      end
    end
  end

  assign rd_a_eff = byp_v_r ? byp_a_r : rd_a;
  assign rd_b_eff = byp_v_r ? byp_b_r : rd_b;
  assign ncol[0]  = rd_b_eff;
  assign ncol[1]  = rd_a_eff;
  assign ncol[2]  = s1_cur_r;

  // row r-1 store
  mgm_ram #(.WIDTH(FW), .DEPTH(MAX_WIDTH)) u_line_mid (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (s1_cur_r),
    .re    (accept),
    .raddr (c),
    .rdata (rd_a)
  );

  // row r-2 store
  mgm_ram #(.WIDTH(FW), .DEPTH(MAX_WIDTH)) u_line_up (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (rd_a_eff),
    .re    (accept),
    .raddr (c),
    .rdata (rd_b)
  );

  // masked neighbor minus centre, per feature
  always_comb begin
    int k;
    logic [FW-1:0] grid [3][3];
    logic present;
    logic [mgm_pkg::FEAT_W-1:0] ctr, nb;
    for (int i = 0; i < 3; i++) begin
      grid[i][0] = lcol_r[i];
      grid[i][1] = ccol_r[i];
      grid[i][2] = ncol[i];
    end
    q_data = '0;
    q_data[JOB_W-1] = s1_last_r;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      k = 0;
      ctr = grid[1][1][j*mgm_pkg::FEAT_W +: mgm_pkg::FEAT_W];
      for (int ri = 0; ri < 3; ri++) begin
        for (int ci = 0; ci < 3; ci++) begin
          if (!(ri == 1 && ci == 1)) begin
            present = !(ri == 0 && s1_mask_r.top) && !(ri == 2 && s1_mask_r.bottom) &&
                      !(ci == 0 && s1_mask_r.left) && !(ci == 2 && s1_mask_r.right);
            nb = grid[ri][ci][j*mgm_pkg::FEAT_W +: mgm_pkg::FEAT_W];
            q_data[(j*mgm_pkg::NBR_COUNT + k)*DW +: DW] =
              present ? ({1'b0, nb} - {1'b0, ctr}) : '0;
            k = k + 1;
          end
        end
      end
    end
  end
endmodule

[src/mgm_back.sv]
// Back part: gradient sums, squares, per-feature maximum and an iterative
// square root, one bit per cycle. Uses mgm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mgm_back #(
  parameter int FEATURE_COUNT = 2,
  parameter int JOB_W         = 273
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  logic [JOB_W-1:0]           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mgm_pkg::MAG_W-1:0]  out_gradient_magnitude,
  output logic                       out_frame_end
);
  localparam int DW = mgm_pkg::DIFF_W;
  localparam int GW = mgm_pkg::GRAD_W;
  localparam int PR = mgm_pkg::PROD_W;

  mgm_pkg::back_state_t state_r, state_nxt;

  logic [JOB_W-1:0]              job_r;
  logic signed [GW-1:0]          gx_r [FEATURE_COUNT];
  logic signed [GW-1:0]          gy_r [FEATURE_COUNT];
  logic [PR-1:0]                 pa_r [FEATURE_COUNT];
  logic [PR-1:0]                 pb_r [FEATURE_COUNT];
  logic [PR-1:0]                 pc_r [FEATURE_COUNT];
  logic [mgm_pkg::Q_W-1:0]       q_r  [FEATURE_COUNT];
  logic [mgm_pkg::Q_W-1:0]       rad_r;
  logic [mgm_pkg::REM_W-1:0]     rem_r;
  logic [mgm_pkg::ROOT_W-1:0]    root_r;
  logic [mgm_pkg::ITER_W-1:0]    iter_r, iter_nxt;
  logic                          out_valid_r;
  logic [mgm_pkg::MAG_W-1:0]     mag_r;
  logic                          fend_r;
  logic                          load_out;

  logic [mgm_pkg::REM_W-1:0]     rem_sh, trial;
  logic [mgm_pkg::Q_W-1:0]       qmax;

  function automatic logic signed [GW-1:0] grad_sum(
    input logic signed [DW-1:0] p_pos, p_neg, d1, d2, d3, d4);
    logic signed [GW-1:0] axial;
    logic signed [DW+1:0] ds;
    logic signed [GW-1:0] diag;
    axial = (GW'(p_pos) - GW'(p_neg)) <<< mgm_pkg::AXIAL_SHIFT;
    ds    = (DW+2)'(d1) + (DW+2)'(d2) - (DW+2)'(d3) - (DW+2)'(d4);
    diag  = GW'(ds) * GW'(mgm_pkg::DIAG_WEIGHT);
    return axial + diag;
  endfunction

  function automatic logic signed [DW-1:0] dv(
    input logic [JOB_W-1:0] job, input int j, input int k);
    return job[(j*mgm_pkg::NBR_COUNT + k)*DW +: DW];
  endfunction

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    iter_nxt  = '0;
    case (state_r)
      mgm_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = mgm_pkg::B_GRAD;
        end
      end
      mgm_pkg::B_GRAD: state_nxt = mgm_pkg::B_SQR;
      mgm_pkg::B_SQR:  state_nxt = mgm_pkg::B_SUM;
      mgm_pkg::B_SUM:  state_nxt = mgm_pkg::B_MAX;
      mgm_pkg::B_MAX:  state_nxt = mgm_pkg::B_ROOT;
      mgm_pkg::B_ROOT: begin
        if (iter_r == mgm_pkg::ITER_W'(mgm_pkg::ROOT_STEPS - 1)) begin
          state_nxt = mgm_pkg::B_DONE;
        end else begin
          iter_nxt = iter_r + mgm_pkg::ITER_W'(1);
        end
      end
      mgm_pkg::B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = mgm_pkg::B_IDLE;
        end
      end
      default: state_nxt = mgm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mgm_pkg::B_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // one bit of the root per step
  always_comb begin
    rem_sh = {rem_r[mgm_pkg::REM_W-3:0], rad_r[mgm_pkg::Q_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    qmax   = '0;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      if (q_r[j] > qmax) begin
        qmax = q_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [mgm_pkg::ABS_W-1:0]  ax, ay;
    logic [mgm_pkg::SUM_W-1:0]  s;
    case (state_r)
      mgm_pkg::B_IDLE: begin
        if (q_pop) begin
          job_r <= q_data;
        end
      end
      mgm_pkg::B_GRAD: begin
        for (int j = 0; j < FEATURE_COUNT; j++) begin
          gx_r[j] <= grad_sum(dv(job_r, j, mgm_pkg::NB_R), dv(job_r, j, mgm_pkg::NB_L),
                              dv(job_r, j, mgm_pkg::NB_TR), dv(job_r, j, mgm_pkg::NB_BR),
                              dv(job_r, j, mgm_pkg::NB_TL), dv(job_r, j, mgm_pkg::NB_BL));
          gy_r[j] <= grad_sum(dv(job_r, j, mgm_pkg::NB_B), dv(job_r, j, mgm_pkg::NB_T),
                              dv(job_r, j, mgm_pkg::NB_BL), dv(job_r, j, mgm_pkg::NB_BR),
                              dv(job_r, j, mgm_pkg::NB_TL), dv(job_r, j, mgm_pkg::NB_TR));
        end
      end
      mgm_pkg::B_SQR: begin
        // split each magnitude into 17-bit halves
        for (int j = 0; j < FEATURE_COUNT; j++) begin
          ax = gx_r[j][GW-1] ? mgm_pkg::ABS_W'(-gx_r[j]) : mgm_pkg::ABS_W'(gx_r[j]);
          ay = gy_r[j][GW-1] ? mgm_pkg::ABS_W'(-gy_r[j]) : mgm_pkg::ABS_W'(gy_r[j]);
          pa_r[j] <= PR'(ax[33:17] * ax[33:17]) + PR'(ay[33:17] * ay[33:17]);
          pb_r[j] <= PR'(ax[33:17] * ax[16:0]) + PR'(ay[33:17] * ay[16:0]);
          pc_r[j] <= PR'(ax[16:0] * ax[16:0]) + PR'(ay[16:0] * ay[16:0]);
        end
      end
      mgm_pkg::B_SUM: begin
        for (int j = 0; j < FEATURE_COUNT; j++) begin
          s = (mgm_pkg::SUM_W'(pa_r[j]) << 34) + (mgm_pkg::SUM_W'(pb_r[j]) << 18) +
              mgm_pkg::SUM_W'(pc_r[j]);
          q_r[j] <= s[mgm_pkg::SUM_W-1:30];
        end
      end
      mgm_pkg::B_MAX: begin
        rad_r  <= qmax;
        rem_r  <= '0;
        root_r <= '0;
      end
      mgm_pkg::B_ROOT: begin
        rad_r <= rad_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[mgm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[mgm_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
        rad_r <= rad_r;
      end
    endcase
    if (load_out) begin
      mag_r  <= (root_r > mgm_pkg::ROOT_W'(mgm_pkg::MAG_LIMIT)) ? mgm_pkg::MAG_LIMIT
                                                                : root_r[mgm_pkg::MAG_W-1:0];
      fend_r <= job_r[JOB_W-1];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_gradient_magnitude = mag_r;
  assign out_frame_end          = fend_r;

  `ASSERT_NEVER(a_iter_only_in_root, (state_r != mgm_pkg::B_ROOT) && (iter_r != '0))
  `ASSERT_ALWAYS(a_result_from_done, $rose(out_valid_r) |-> $past(state_r) == mgm_pkg::B_DONE)
  `ASSERT_NEVER(a_pop_only_idle, q_pop && (state_r != mgm_pkg::B_IDLE))
endmodule

[src/multichannel_gradient_magnitude_top.sv]
// Multichannel 3x3 gradient magnitude, top level. Results leave one row plus one
// pixel late. Items without a result are taken one per cycle unless a job waits
// on a full queue; items with a result are limited by the back, which handles one
// job at a time through 20 square root steps plus six other states.
// Reset clears control state and restores width 640 and height 480; line stores
// are not cleared, their unwritten entries are never used unmasked.
`timescale 1ns / 1ps
module multichannel_gradient_magnitude_top #(
  parameter int MAX_WIDTH     = 4096,
  parameter int FEATURE_COUNT = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mgm_pkg::FEAT_W-1:0]  in_feature_first,
  input  logic [mgm_pkg::FEAT_W-1:0]  in_feature_second,
  input  logic                        in_is_padding,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mgm_pkg::MAG_W-1:0]   out_gradient_magnitude,
  output logic                        out_frame_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [mgm_pkg::CFG_W-1:0]   cfg_data
);
  localparam int JOB_W = FEATURE_COUNT * mgm_pkg::NBR_COUNT * mgm_pkg::DIFF_W + 1;

  logic             q_push, q_pop, q_full, q_empty;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  mgm_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .FEATURE_COUNT (FEATURE_COUNT),
    .JOB_W         (JOB_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_feature_first  (in_feature_first),
    .in_feature_second (in_feature_second),
    .in_is_padding     (in_is_padding),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_wdata)
  );

  mgm_fifo #(.WIDTH(JOB_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mgm_back #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .JOB_W         (JOB_W)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_data                 (q_rdata),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_gradient_magnitude (out_gradient_magnitude),
    .out_frame_end          (out_frame_end)
  );
endmodule

[verif/tb_multichannel_gradient_magnitude_top.sv]
// Self-checking testbench for multichannel_gradient_magnitude_top.
// Streams raster frames with a queue-fed driver, predicts each gradient result in
// place and checks every output beat; depends on mgm_pkg and the top level only.
`timescale 1ns / 1ps
module tb_multichannel_gradient_magnitude_top;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_GAP   = 40;
  localparam int ROW_SLOTS   = 4;
  localparam int STORE_DEPTH = 4096;
  localparam int DIAG_Q15    = 23170;
  localparam int AXIAL_Q15   = 32768;

  typedef struct {
    logic [mgm_pkg::FEAT_W-1:0] feat_a;
    logic [mgm_pkg::FEAT_W-1:0] feat_b;
    logic                       pad;
  } pixel_beat_t;

  typedef struct {
    logic [mgm_pkg::MAG_W-1:0] mag;
    logic                      frame_end;
  } grad_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mgm_pkg::FEAT_W-1:0] in_feature_first = '0;
  logic [mgm_pkg::FEAT_W-1:0] in_feature_second = '0;
  logic in_is_padding = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mgm_pkg::MAG_W-1:0] out_gradient_magnitude;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = mgm_pkg::REG_WIDTH;
  logic [mgm_pkg::CFG_W-1:0] cfg_data = '0;

  pixel_beat_t  pending_pixels[$];
  grad_result_t expected_grads[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  // predictor state
  logic [mgm_pkg::FEAT_W-1:0] row_mem [ROW_SLOTS][STORE_DEPTH][2];
  int unsigned frame_w = 640;
  int unsigned frame_h = 480;
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;

  multichannel_gradient_magnitude_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_feature_first(in_feature_first), .in_feature_second(in_feature_second),
    .in_is_padding(in_is_padding),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_gradient_magnitude(out_gradient_magnitude), .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    if (frame_w < 1) return 1;
    if (frame_w > STORE_DEPTH) return STORE_DEPTH;
    return frame_w;
  endfunction

  function automatic int unsigned eff_h();
    return (frame_h < 1) ? 1 : frame_h;
  endfunction

  // floor(sqrt(gx^2 + gy^2) / 2^15) as an unsigned Q19.0 integer, saturated
  function automatic logic [mgm_pkg::MAG_W-1:0] grad_norm(longint gx, longint gy);
    logic signed [79:0] sx;
    logic signed [79:0] sy;
    logic [79:0] sq;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    sx = gx;
    sy = gy;
    sq = sx * sx + sy * sy;
    rem = 64'(sq >> 30);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return (root > mgm_pkg::MAG_LIMIT) ? mgm_pkg::MAG_LIMIT : root[mgm_pkg::MAG_W-1:0];
  endfunction

  function automatic logic [mgm_pkg::MAG_W-1:0] window_grad(int cr, int cc, int w, int h);
    logic [mgm_pkg::MAG_W-1:0] best;
    logic [mgm_pkg::MAG_W-1:0] m;
    longint gx;
    longint gy;
    longint d;
    longint wgt;
    int centre;
    int r;
    int c;
    best = 0;
    for (int j = 0; j < 2; j++) begin
      centre = row_mem[cr % ROW_SLOTS][cc][j];
      gx = 0;
      gy = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          r = cr + dy;
          c = cc + dx;
          if ((dx != 0 || dy != 0) && r >= 0 && r < h && c >= 0 && c < w) begin
            d = longint'(row_mem[r % ROW_SLOTS][c][j]) - centre;
            wgt = (dx != 0 && dy != 0) ? DIAG_Q15 : AXIAL_Q15;
            gx += d * dx * wgt;
            gy += d * dy * wgt;
          end
        end
      end
      m = grad_norm(gx, gy);
      if (m > best) best = m;
    end
    return best;
  endfunction

  function automatic void predict_pixel(pixel_beat_t pb);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int cr;
    int cc;
    bit emit;
    bit last;
    grad_result_t res;
    w = eff_w();
    h = eff_h();
    r = pos_row;
    c = pos_col;
    emit = 0;
    if (c >= w || r > h + 1 || (r == h + 1 && c != 0)) begin
      r = 0;
      c = 0;
    end
    // padding inside the frame stores zeros
    if (r < h) begin
      row_mem[r % ROW_SLOTS][c][0] = pb.pad ? '0 : pb.feat_a;
      row_mem[r % ROW_SLOTS][c][1] = pb.pad ? '0 : pb.feat_b;
    end
    if (c >= 1 && r >= 1 && r <= h) begin
      cr = r - 1;
      cc = c - 1;
      emit = 1;
    end else if (c == 0 && r >= 2) begin
      cr = r - 2;
      cc = w - 1;
      emit = 1;
    end
    last = (r == h + 1);
    if (last) begin
      r = 0;
      c = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
    end
    pos_row = r;
    pos_col = c;
    if (emit) begin
      res.mag = window_grad(cr, cc, w, h);
      res.frame_end = last;
      expected_grads.push_back(res);
    end
  endfunction

  // driver: advance only when the current beat is taken or none is held
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_pixel('{in_feature_first, in_feature_second, in_is_padding});
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_beat_t pb;
          pb = pending_pixels.pop_front();
          in_feature_first  <= pb.feat_a;
          in_feature_second <= pb.feat_b;
          in_is_padding     <= pb.pad;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_grads.size() == 0) begin
          $error("unexpected result: gradient_magnitude %0d frame_end %0d",
                 out_gradient_magnitude, out_frame_end);
          error_count++;
        end else begin
          grad_result_t exp_r;
          exp_r = expected_grads.pop_front();
          if (out_gradient_magnitude !== exp_r.mag) begin
            $error("gradient_magnitude expected %0d actual %0d",
                   exp_r.mag, out_gradient_magnitude);
            error_count++;
          end
          if (out_frame_end !== exp_r.frame_end) begin
            $error("frame_end expected %0d actual %0d", exp_r.frame_end, out_frame_end);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_multichannel_gradient_magnitude_top: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_grads.size() != 0)
      @(posedge clk);
    // items without a result may still be in flight
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last beat
  task automatic write_reg(logic idx, logic [mgm_pkg::CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mgm_pkg::REG_WIDTH) frame_w = val;
    else frame_h = val;
    pos_col = 0;
    pos_row = 0;
  endtask

  task automatic set_frame(int w, int h);
    wait_drained();
    write_reg(mgm_pkg::REG_WIDTH, mgm_pkg::CFG_W'(w));
    write_reg(mgm_pkg::REG_HEIGHT, mgm_pkg::CFG_W'(h));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [mgm_pkg::FEAT_W-1:0] pick_feat(int style);
    case (style)
      0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1: return 16'h8000 + 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // queue one frame, cut short after max_beats; noise adds padding in the
  // frame and pixels in the flush row
  task automatic queue_frame(int w, int h, int max_beats, bit noisy);
    pixel_beat_t pb;
    int ew;
    int eh;
    int n;
    int style;
    ew = (w < 1) ? 1 : (w > STORE_DEPTH ? STORE_DEPTH : w);
    eh = (h < 1) ? 1 : h;
    n = 0;
    style = $urandom_range(2);
    for (int r = 0; r <= eh + 1; r++) begin
      for (int c = 0; c < ((r == eh + 1) ? 1 : ew); c++) begin
        if (n >= max_beats) return;
        pb.feat_a = pick_feat(style);
        pb.feat_b = pick_feat(style);
        if (r < eh) pb.pad = noisy && ($urandom_range(19) == 0);
        else pb.pad = !(noisy && $urandom_range(4) == 0);
        pending_pixels.push_back(pb);
        n++;
      end
    end
  endtask

  task automatic random_frames(int beats);
    int w;
    int h;
    int sent;
    sent = 0;
    while (sent < beats) begin
      w = $urandom_range(12, 1);
      h = $urandom_range(6, 1);
      set_frame(w, h);
      if ($urandom_range(9) == 0) begin
        queue_frame(w, h, $urandom_range(w * h, 1), 1'b1);
      end else begin
        queue_frame(w, h, 1 << 30, $urandom_range(3) == 0);
      end
      sent += w * h + w + 1;
    end
  endtask

  initial begin
    for (int s = 0; s < ROW_SLOTS; s++)
      for (int i = 0; i < STORE_DEPTH; i++) begin
        row_mem[s][i][0] = '0;
        row_mem[s][i][1] = '0;
      end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_stall_pct = 83;
    // 3x3 with a vertical edge, a padded pixel and a pixel during flush
    set_frame(3, 3);
    for (int i = 0; i < 9; i++)
      pending_pixels.push_back('{(i % 3 == 2) ? 16'hFFFF : 16'h0000,
                                 (i / 3 == 0) ? 16'hFFFF : 16'h1234, i == 4});
    pending_pixels.push_back('{16'hFFFF, 16'hFFFF, 1'b0});
    pending_pixels.push_back('{16'h0000, 16'h0000, 1'b1});
    pending_pixels.push_back('{16'h0000, 16'h0000, 1'b1});
    pending_pixels.push_back('{16'h0000, 16'h0000, 1'b1});
    // zero width and height act as a single pixel frame
    set_frame(0, 0);
    queue_frame(0, 0, 1 << 30, 1'b0);
    set_frame(1, 5);
    queue_frame(1, 5, 1 << 30, 1'b1);
    random_frames(370);

    send_idle_pct = 83;
    recv_stall_pct = 9;
    random_frames(370);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    // oversized width clamps to the store depth
    set_frame(8191, 1);
    queue_frame(8191, 1, 40, 1'b1);
    set_frame(2, 8191);
    queue_frame(2, 8191, 40, 1'b1);
    set_frame(4096, 2);
    queue_frame(4096, 2, 40, 1'b0);
    random_frames(370);

    wait_drained();
    if (error_count == 0) begin
      $display("tb_multichannel_gradient_magnitude_top: done, clean");
    end else begin
      $display("tb_multichannel_gradient_magnitude_top: done, errors");
    end
    $finish;
  end
endmodule
